/* src/uvsph_pkg.sv */
package uvsph_pkg;

	localparam int MAX_DIVISIONS_DEF   = 64;
	localparam int TRIG_TABLE_BITS_DEF = 10;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		KIND_VERTEX   = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_STACKS = 2'd1,
		REG_SECTORS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] radius;
		logic [6:0]  stack_count;
		logic [6:0]  sector_count;
	} cfg_t;

	// one grid point after classification and arithmetic
	typedef struct packed {
		logic                err;
		logic                t1;
		logic                t2;
		logic signed [16:0]  x;
		logic signed [16:0]  y;
		logic signed [16:0]  z;
		logic signed [15:0]  nx;
		logic signed [15:0]  ny;
		logic signed [15:0]  nz;
		logic [16:0]         u;
		logic [16:0]         v;
		logic [16:0]         k1;
		logic [16:0]         k2;
	} qe_t;

	// quarter-wave sine in Q1.14, Taylor series in Q30; elaboration only
	function automatic logic [14:0] quarter_sine(int r, int qbits);
		logic [63:0] t, x, x2, a, s;
		t  = 64'(r) << (30 - qbits);
		x  = (t * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		a  = Q30_ONE - x2 / 64'd72;
		a  = Q30_ONE - ((x2 * a) >> 30) / 64'd42;
		a  = Q30_ONE - ((x2 * a) >> 30) / 64'd20;
		a  = Q30_ONE - ((x2 * a) >> 30) / 64'd6;
		s  = (x * a) >> 30;
		s  = (s + 64'd32768) >> 16;
		if (s > 64'd16384)
			s = 64'd16384;
		return 15'(s);
	endfunction

	// round half away from zero, then drop sh bits
	function automatic logic signed [63:0] round_sh(logic signed [63:0] v, int sh);
		logic        neg;
		logic [63:0] mag;
		neg = v[63];
		mag = neg ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

/* src/uv_sphere_mesh_generator_unit.sv */
// UV sphere tessellator. Each grid point (stack_index, sector_index) yields a vertex
// result, then for a cell origin up to two triangle results, or one error result
// when the point lies off the grid; last marks the final result of a point. The
// front pipeline (pipelined long division of the phases and texture coordinates,
// sine table, two multiplier stages) takes one point per cycle unless a full queue
// stalls it; the result serializer after a 4-entry queue emits one result per cycle
// while out_stall is low, so sustained intake is limited by the one to three results
// each point produces. Config writes are always ready and apply at once; write only
// while the block holds no points.
module uv_sphere_mesh_generator_unit #(
	parameter int MAX_DIVISIONS   = uvsph_pkg::MAX_DIVISIONS_DEF,
	parameter int TRIG_TABLE_BITS = uvsph_pkg::TRIG_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [6:0]         stack_index,
	input  logic [6:0]         sector_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [16:0] word_a,
	output logic signed [16:0] word_b,
	output logic signed [16:0] word_c,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               last
);

	uvsph_pkg::cfg_t cfg_q;
	uvsph_pkg::qe_t  wr_entry, head;
	logic            push, full, pop, nonempty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius       <= 16'd256;
			cfg_q.stack_count  <= 7'd16;
			cfg_q.sector_count <= 7'd32;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				uvsph_pkg::REG_RADIUS:  cfg_q.radius       <= cfg_data;
				uvsph_pkg::REG_STACKS:  cfg_q.stack_count  <= cfg_data[6:0];
				uvsph_pkg::REG_SECTORS: cfg_q.sector_count <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	uvsph_front #(
		.MAX_DIVISIONS  (MAX_DIVISIONS),
		.TRIG_TABLE_BITS(TRIG_TABLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stack_index (stack_index),
		.sector_index(sector_index),
		.q_push      (push),
		.q_entry     (wr_entry),
		.q_full      (full)
	);

	uvsph_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (wr_entry),
		.full    (full),
		.pop     (pop),
		.nonempty(nonempty),
		.rdata   (head)
	);

	uvsph_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.word_a   (word_a),
		.word_b   (word_b),
		.word_c   (word_c),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z),
		.tex_u    (tex_u),
		.tex_v    (tex_v),
		.last     (last)
	);

endmodule

/* src/uvsph_front.sv */
module uvsph_front #(
	parameter int MAX_DIVISIONS   = uvsph_pkg::MAX_DIVISIONS_DEF,
	parameter int TRIG_TABLE_BITS = uvsph_pkg::TRIG_TABLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  uvsph_pkg::cfg_t  cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [6:0]       stack_index,
	input  logic [6:0]       sector_index,
	output logic             q_push,
	output uvsph_pkg::qe_t   q_entry,
	input  logic             q_full
);

	localparam int TB     = TRIG_TABLE_BITS;
	localparam int QB     = TB - 2;
	localparam int QSIZE  = 1 << QB;
	localparam int DIV_W  = 24;
	localparam int DBITS  = 4;
	localparam int DSTEPS = DIV_W / DBITS;
	localparam int ST_CLS = 1;
	localparam int ST_LUT = ST_CLS + DSTEPS + 1;
	localparam int ST_MUL = ST_LUT + 1;
	localparam int ST_BIG = ST_MUL + 1;
	localparam int ST_RND = ST_BIG + 1;
	localparam int NST    = ST_RND + 1;

	typedef struct packed {
		logic [DIV_W-1:0] n;
		logic [DIV_W-1:0] q;
		logic [6:0]       r;
	} div_t;

	// dv: 0 tex_v, 1 tex_u, 2 theta phase, 3 phi phase
	typedef struct packed {
		logic [6:0]          i;
		logic [6:0]          j;
		logic [6:0]          st;
		logic [6:0]          se;
		logic                err;
		logic                t1;
		logic                t2;
		logic [16:0]         k1;
		logic [16:0]         k2;
		div_t [3:0]          dv;
		logic signed [15:0]  s_t;
		logic signed [15:0]  c_t;
		logic signed [15:0]  s_p;
		logic signed [15:0]  c_p;
		logic signed [31:0]  pa;
		logic signed [31:0]  pb;
		logic signed [32:0]  pz;
		logic signed [48:0]  xf;
		logic signed [48:0]  yf;
		logic signed [16:0]  x;
		logic signed [16:0]  y;
		logic signed [16:0]  z;
		logic signed [15:0]  nx;
		logic signed [15:0]  ny;
	} fp_t;

	typedef logic [14:0] sintab_t [QSIZE];

	function automatic sintab_t build_sintab();
		sintab_t t;
		for (int r = 0; r < QSIZE; r++)
			t[r] = uvsph_pkg::quarter_sine(r, QB);
		return t;
	endfunction

	localparam sintab_t SIN_TAB = build_sintab();

	function automatic logic signed [15:0] sine(logic [TB-1:0] ph);
		logic [1:0]  quad;
		logic [QB:0] idx;
		logic [14:0] mag;
		quad = ph[TB-1 -: 2];
		idx  = quad[0] ? (QB+1)'(QSIZE) - {1'b0, ph[QB-1:0]} : {1'b0, ph[QB-1:0]};
		mag  = idx[QB] ? 15'd16384 : SIN_TAB[idx[QB-1:0]];
		return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	function automatic logic [6:0] eff(logic [6:0] c);
		if (c == 7'd0)
			return 7'd1;
		if (int'(c) > MAX_DIVISIONS)
			return 7'(MAX_DIVISIONS);
		return c;
	endfunction

	function automatic fp_t div_step(fp_t p);
		fp_t        o;
		logic [6:0] d;
		logic [7:0] tmp;
		o = p;
		for (int k = 0; k < 4; k++) begin
			d = k[0] ? p.se : p.st;
			for (int b = 0; b < DBITS; b++) begin
				tmp = {o.dv[k].r, o.dv[k].n[DIV_W-1]};
				o.dv[k].n = o.dv[k].n << 1;
				if (tmp >= {1'b0, d}) begin
					o.dv[k].q = {o.dv[k].q[DIV_W-2:0], 1'b1};
					o.dv[k].r = 7'(tmp - {1'b0, d});
				end else begin
					o.dv[k].q = {o.dv[k].q[DIV_W-2:0], 1'b0};
					o.dv[k].r = tmp[6:0];
				end
			end
		end
		return o;
	endfunction

	fp_t        pipe_s [NST];
	fp_t        nxt    [NST];
	logic [NST-1:0] vld_s;
	logic       adv;
	logic signed [16:0] rad;

	assign rad      = $signed({1'b0, cfg.radius});
	assign adv      = !(vld_s[NST-1] && q_full);
	assign in_stall = !adv;
	assign q_push   = vld_s[NST-1] && !q_full;

	always_comb begin
		fp_t c;
		c = '0;
		for (int k = 0; k < NST; k++)
			nxt[k] = (k == 0) ? '0 : pipe_s[k-1];

		c.i = stack_index;
		c.j = sector_index;
		nxt[0] = c;

		c = pipe_s[0];
		c.st  = eff(cfg.stack_count);
		c.se  = eff(cfg.sector_count);
		c.err = (c.i > c.st) || (c.j > c.se);
		c.t1  = (c.i < c.st) && (c.j < c.se) && (c.i != 7'd0);
		c.t2  = (c.i < c.st) && (c.j < c.se) && (c.i != c.st - 7'd1);
		c.k1  = 17'(c.i) * (17'(c.se) + 17'd1) + 17'(c.j);
		c.k2  = c.k1 + 17'(c.se) + 17'd1;
		c.dv  = '0;
		c.dv[0].n = (DIV_W'(c.i) << 16) + DIV_W'(c.st >> 1);
		c.dv[1].n = (DIV_W'(c.j) << 16) + DIV_W'(c.se >> 1);
		c.dv[2].n = (DIV_W'(c.i) << (TB - 1)) + DIV_W'(c.st >> 1);
		c.dv[3].n = (DIV_W'(c.j) << TB) + DIV_W'(c.se >> 1);
		nxt[ST_CLS] = c;

		for (int d = 0; d < DSTEPS; d++)
			nxt[ST_CLS+1+d] = div_step(pipe_s[ST_CLS+d]);

		c = pipe_s[ST_LUT-1];
		c.s_t = sine(c.dv[2].q[TB-1:0]);
		c.c_t = sine(c.dv[2].q[TB-1:0] + TB'(QSIZE));
		c.s_p = sine(c.dv[3].q[TB-1:0]);
		c.c_p = sine(c.dv[3].q[TB-1:0] + TB'(QSIZE));
		nxt[ST_LUT] = c;

		c = pipe_s[ST_MUL-1];
		c.pa = c.s_t * c.c_p;
		c.pb = c.s_t * c.s_p;
		c.pz = rad * c.c_t;
		nxt[ST_MUL] = c;

		c = pipe_s[ST_BIG-1];
		c.xf = rad * c.pa;
		c.yf = rad * c.pb;
		c.nx = 16'(uvsph_pkg::round_sh(64'(c.pa), 14));
		c.ny = 16'(uvsph_pkg::round_sh(64'(c.pb), 14));
		c.z  = 17'(uvsph_pkg::round_sh(64'(c.pz), 14));
		nxt[ST_BIG] = c;

		c = pipe_s[ST_RND-1];
		c.x = 17'(uvsph_pkg::round_sh(64'(c.xf), 28));
		c.y = 17'(uvsph_pkg::round_sh(64'(c.yf), 28));
		nxt[ST_RND] = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NST; k++)
				pipe_s[k] <= nxt[k];
		end
	end

	always_comb begin
		fp_t l;
		l = pipe_s[NST-1];
		q_entry.err = l.err;
		q_entry.t1  = l.t1;
		q_entry.t2  = l.t2;
		q_entry.x   = l.x;
		q_entry.y   = l.y;
		q_entry.z   = l.z;
		q_entry.nx  = l.nx;
		q_entry.ny  = l.ny;
		q_entry.nz  = l.c_t;
		q_entry.u   = l.dv[1].q[16:0];
		q_entry.v   = l.dv[0].q[16:0];
		q_entry.k1  = l.k1;
		q_entry.k2  = l.k2;
	end

endmodule

/* src/uvsph_fifo.sv */
module uvsph_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  uvsph_pkg::qe_t  wdata,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output uvsph_pkg::qe_t  rdata
);

	uvsph_pkg::qe_t                 mem_q [uvsph_pkg::QDEPTH];
	logic [uvsph_pkg::QPTR_W-1:0]   wp_q, rp_q;
	logic [uvsph_pkg::QPTR_W:0]     cnt_q;

	assign full     = (cnt_q == (uvsph_pkg::QPTR_W+1)'(uvsph_pkg::QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (uvsph_pkg::QPTR_W+1)'(push) - (uvsph_pkg::QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

/* src/uvsph_back.sv */
module uvsph_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               nonempty,
	input  uvsph_pkg::qe_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [16:0] word_a,
	output logic signed [16:0] word_b,
	output logic signed [16:0] word_c,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               last
);

	typedef enum logic [1:0] {PH_VTX, PH_T1, PH_T2} phase_t;

	phase_t phase_q;
	logic   ld, is_last;

	assign ld = !out_valid || !out_stall;

	always_comb begin
		is_last = 1'b1;
		unique case (phase_q)
			PH_VTX:  is_last = head.err || (!head.t1 && !head.t2);
			PH_T1:   is_last = !head.t2;
			PH_T2:   is_last = 1'b1;
			default: is_last = 1'b1;
		endcase
	end

	assign pop = ld && nonempty && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_VTX;
			out_valid <= 1'b0;
		end else if (ld) begin
			out_valid <= nonempty;
			if (nonempty) begin
				if (is_last)
					phase_q <= PH_VTX;
				else if (phase_q == PH_VTX && head.t1)
					phase_q <= PH_T1;
				else
					phase_q <= PH_T2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld && nonempty) begin
			last     <= is_last;
			normal_x <= '0;
			normal_y <= '0;
			normal_z <= '0;
			tex_u    <= '0;
			tex_v    <= '0;
			word_a   <= '0;
			word_b   <= '0;
			word_c   <= '0;
			if (head.err) begin
				kind <= uvsph_pkg::KIND_ERROR;
			end else begin
				unique case (phase_q)
					PH_VTX: begin
						kind     <= uvsph_pkg::KIND_VERTEX;
						word_a   <= head.x;
						word_b   <= head.y;
						word_c   <= head.z;
						normal_x <= head.nx;
						normal_y <= head.ny;
						normal_z <= head.nz;
						tex_u    <= head.u;
						tex_v    <= head.v;
					end
					PH_T1: begin
						kind   <= uvsph_pkg::KIND_TRIANGLE;
						word_a <= $signed(head.k1);
						word_b <= $signed(head.k1 + 17'd1);
						word_c <= $signed(head.k2);
					end
					default: begin
						kind   <= uvsph_pkg::KIND_TRIANGLE;
						word_a <= $signed(head.k1 + 17'd1);
						word_b <= $signed(head.k2 + 17'd1);
						word_c <= $signed(head.k2);
					end
				endcase
			end
		end
	end

endmodule

/* src/uvsph_checker.sv */
module uvsph_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         kind,
	input logic [15:0]        normal_x,
	input logic [16:0]        tex_u,
	input logic               last
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
		else $error("stalled result changed");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == uvsph_pkg::KIND_ERROR |-> last)
		else $error("error result without last");

	a_tri_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == uvsph_pkg::KIND_TRIANGLE |-> normal_x == '0 && tex_u == '0)
		else $error("triangle carries vertex fields");

	// results of one point come back to back, and only triangles follow
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && kind == uvsph_pkg::KIND_TRIANGLE)
		else $error("broken result burst");

endmodule

bind uv_sphere_mesh_generator_unit uvsph_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind     (kind),
	.normal_x (normal_x),
	.tex_u    (tex_u),
	.last     (last)
);
